>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, constants and the field layout table of the sensor frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES = 64;
  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int NUM_FIELDS = 24;
  localparam int FID_W = 5;

  localparam logic [7:0] SYNC0 = 8'h42;
  localparam logic [7:0] SYNC1 = 8'h4D;
  localparam logic [15:0] LEN_EXPECTED = 16'(FRAME_BYTES - 4);

  localparam logic [POS_W-1:0] POS_SYNC0 = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(4);
  localparam logic [POS_W-1:0] POS_AQI = POS_W'(8'h3A);
  localparam logic [POS_W-1:0] POS_ERR = POS_W'(8'h3D);
  localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_CHK_LO = POS_W'(FRAME_BYTES - 1);

  localparam logic [FID_W-1:0] FID_FIRST = FID_W'(0);
  localparam logic [FID_W-1:0] FID_LAST = FID_W'(NUM_FIELDS - 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  // Item operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FIELD    = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_CHK  = 2'd2,
    ST_ZERO_AQI = 2'd3
  } status_t;

  // One job from the front to the back. ST_FIELD asks for the full field run.
  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic        warn;
  } job_t;

  // Queue fill state seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Byte offset of each field within the frame.
  function automatic logic [POS_W-1:0] field_offset(input logic [FID_W-1:0] id);
    logic [7:0] off;
    case (id)
      5'd0:  off = 8'h04;
      5'd1:  off = 8'h06;
      5'd2:  off = 8'h08;
      5'd3:  off = 8'h0A;
      5'd4:  off = 8'h0C;
      5'd5:  off = 8'h0E;
      5'd6:  off = 8'h10;
      5'd7:  off = 8'h12;
      5'd8:  off = 8'h14;
      5'd9:  off = 8'h16;
      5'd10: off = 8'h18;
      5'd11: off = 8'h1A;
      5'd12: off = 8'h1C;
      5'd13: off = 8'h1E;
      5'd14: off = 8'h22;
      5'd15: off = 8'h24;
      5'd16: off = 8'h26;
      5'd17: off = 8'h28;
      5'd18: off = 8'h2A;
      5'd19: off = 8'h2E;
      5'd20: off = 8'h32;
      5'd21: off = 8'h36;
      5'd22: off = 8'h3A;
      5'd23: off = 8'h3D;
      default: off = 8'h00;
    endcase
    return POS_W'(off);
  endfunction

  // Width in bytes of each field.
  function automatic logic [2:0] field_size(input logic [FID_W-1:0] id);
    logic [2:0] sz;
    case (id) inside
      [5'd18:5'd21]: sz = 3'd4;
      5'd22, 5'd23:  sz = 3'd1;
      default:       sz = 3'd2;
    endcase
    return sz;
  endfunction

endpackage

>>> rtl/sfr_in_if.sv
// ----------------------------------------------------------------------------
// sfr_in_if
// Input channel: one received byte or one millisecond tick per item.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

>>> rtl/sfr_out_if.sv
// ----------------------------------------------------------------------------
// sfr_out_if
// Result channel: one decoded field or one frame status per item.
// ----------------------------------------------------------------------------
interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  field_id;
  logic [31:0] field_value;
  logic        sensor_warning;
  logic        last;

  modport source (
    output valid, output status, output field_id, output field_value,
    output sensor_warning, output last, input ready
  );
  modport sink (
    input valid, input status, input field_id, input field_value,
    input sensor_warning, input last, output ready
  );
endinterface

>>> rtl/sfr_cfg_if.sv
// ----------------------------------------------------------------------------
// sfr_cfg_if
// Configuration write channel for the idle timeout register.
// ----------------------------------------------------------------------------
interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

>>> rtl/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Frame parser: tracks the byte position, the running sum and the idle
// timer, stores frame bytes and posts one job per frame outcome.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic                              clk,
  input  logic                              rst,
  sfr_in_if.sink                            items,
  sfr_cfg_if.sink                           cfg,
  input  sfr_pkg::queue_stat_t              q_stat,
  input  logic                              fields_done,
  output logic                              push,
  output sfr_pkg::job_t                     job,
  output logic                              ram_we,
  output logic [sfr_pkg::POS_W-1:0]         ram_waddr,
  output logic [7:0]                        ram_wdata
);

  logic [sfr_pkg::POS_W-1:0] pos, pos_next;
  logic [15:0] sum, sum_next;
  logic [15:0] idle, idle_next;
  logic [15:0] timeout;
  logic [7:0]  len_hi, len_hi_next;
  logic [7:0]  chk_hi, chk_hi_next;
  logic        aqi_nz, aqi_nz_next;
  logic        err_nz, err_nz_next;
  logic        field_pending;
  logic        accept;
  logic [15:0] sum_add;
  logic [15:0] idle_inc;
  logic [15:0] word;

  // Payload bytes must not overwrite a frame whose fields are still being read.
  assign items.ready = !q_stat.full &&
                       !(field_pending && (pos >= sfr_pkg::POS_PAYLOAD));
  assign accept = items.valid && items.ready;
  assign cfg.ready = 1'b1;

  assign ram_we = accept && (items.operation == sfr_pkg::OP_BYTE);
  assign ram_waddr = pos;
  assign ram_wdata = items.rx_byte;

  assign sum_add = sum + {8'h00, items.rx_byte};
  assign idle_inc = (idle != sfr_pkg::IDLE_MAX) ? idle + 16'd1 : idle;

  // Parser next state and job generation.
  always_comb begin
    pos_next = pos;
    sum_next = sum;
    idle_next = idle;
    len_hi_next = len_hi;
    chk_hi_next = chk_hi;
    aqi_nz_next = aqi_nz;
    err_nz_next = err_nz;
    push = 1'b0;
    job = '{status: sfr_pkg::ST_FIELD, value: 32'd0, warn: 1'b0};
    word = 16'd0;
    if (accept) begin
      if (items.operation == sfr_pkg::OP_TICK) begin
        idle_next = idle_inc;
        if (idle_inc >= timeout) begin
          pos_next = sfr_pkg::POS_SYNC0;
        end
      end else begin
        idle_next = 16'd0;
        if (pos == sfr_pkg::POS_SYNC0) begin
          sum_next = {8'h00, items.rx_byte};
          pos_next = (items.rx_byte == sfr_pkg::SYNC0) ? sfr_pkg::POS_SYNC1
                                                       : sfr_pkg::POS_SYNC0;
        end else if (pos == sfr_pkg::POS_SYNC1) begin
          sum_next = sum_add;
          pos_next = (items.rx_byte == sfr_pkg::SYNC1) ? sfr_pkg::POS_LEN_HI
                                                       : sfr_pkg::POS_SYNC0;
        end else if (pos == sfr_pkg::POS_LEN_HI) begin
          sum_next = sum_add;
          len_hi_next = items.rx_byte;
          pos_next = sfr_pkg::POS_LEN_LO;
        end else if (pos == sfr_pkg::POS_LEN_LO) begin
          sum_next = sum_add;
          word = {len_hi, items.rx_byte};
          if (word != sfr_pkg::LEN_EXPECTED) begin
            push = 1'b1;
            job = '{status: sfr_pkg::ST_BAD_LEN, value: {16'h0000, word}, warn: 1'b0};
            pos_next = sfr_pkg::POS_SYNC0;
          end else begin
            pos_next = sfr_pkg::POS_PAYLOAD;
          end
        end else if (pos < sfr_pkg::POS_CHK_HI) begin
          sum_next = sum_add;
          pos_next = pos + 1'b1;
          if (pos == sfr_pkg::POS_AQI) begin
            aqi_nz_next = (items.rx_byte != 8'h00);
          end
          if (pos == sfr_pkg::POS_ERR) begin
            err_nz_next = (items.rx_byte != 8'h00);
          end
        end else if (pos == sfr_pkg::POS_CHK_HI) begin
          chk_hi_next = items.rx_byte;
          pos_next = sfr_pkg::POS_CHK_LO;
        end else begin
          // Final byte: checksum, then the AQI gate, then the field run.
          pos_next = sfr_pkg::POS_SYNC0;
          word = {chk_hi, items.rx_byte};
          push = 1'b1;
          if (word != sum) begin
            job = '{status: sfr_pkg::ST_BAD_CHK, value: {16'h0000, word}, warn: 1'b0};
          end else if (!aqi_nz) begin
            job = '{status: sfr_pkg::ST_ZERO_AQI, value: 32'd0, warn: 1'b0};
          end else begin
            job = '{status: sfr_pkg::ST_FIELD, value: 32'd0, warn: err_nz};
          end
        end
      end
    end
  end

  // Parser registers, timeout register and the outstanding field run flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= sfr_pkg::POS_SYNC0;
      sum <= 16'd0;
      idle <= 16'd0;
      timeout <= sfr_pkg::TIMEOUT_RESET;
      field_pending <= 1'b0;
    end else begin
      pos <= pos_next;
      sum <= sum_next;
      idle <= idle_next;
      if (cfg.valid && cfg.ready) begin
        timeout <= cfg.timeout_ticks;
      end
      if (push && (job.status == sfr_pkg::ST_FIELD)) begin
        field_pending <= 1'b1;
      end else if (fields_done) begin
        field_pending <= 1'b0;
      end
    end
    len_hi <= len_hi_next;
    chk_hi <= chk_hi_next;
    aqi_nz <= aqi_nz_next;
    err_nz <= err_nz_next;
  end

endmodule

>>> rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry job queue between the frame parser and the result emitter.
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfr_pkg::job_t        push_job,
  input  logic                 pop,
  output sfr_pkg::job_t        head,
  output sfr_pkg::queue_stat_t stat
);

  sfr_pkg::job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head = entries[rd_ptr];
  assign stat.full = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  // Storage is written only at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Result emitter: turns queued jobs into result items, reading field bytes
// from the frame store one byte at a time.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  sfr_pkg::job_t             head,
  input  sfr_pkg::queue_stat_t      q_stat,
  output logic                      pop,
  output logic                      fields_done,
  output logic [sfr_pkg::POS_W-1:0] ram_raddr,
  input  logic [7:0]                ram_rdata,
  sfr_out_if.source                 results
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_DATA,
    S_SEND
  } state_t;

  state_t                    state;
  logic [sfr_pkg::FID_W-1:0] fid;
  logic [1:0]                byte_idx;
  logic                      is_fields;
  logic                      warn;
  logic [31:0]               acc;
  logic [2:0]                size;
  logic                      sent;

  assign size = sfr_pkg::field_size(fid);
  assign ram_raddr = sfr_pkg::field_offset(fid) + sfr_pkg::POS_W'(byte_idx);
  assign pop = (state == S_IDLE) && !q_stat.empty;
  assign sent = (state == S_SEND) && results.ready;
  assign fields_done = sent && is_fields && (fid == sfr_pkg::FID_LAST);

  assign results.valid = (state == S_SEND);
  assign results.field_value = acc;

  // Sequencer with the registered result payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            is_fields <= (head.status == sfr_pkg::ST_FIELD);
            warn <= head.warn;
            fid <= sfr_pkg::FID_FIRST;
            byte_idx <= 2'd0;
            if (head.status == sfr_pkg::ST_FIELD) begin
              state <= S_ADDR;
            end else begin
              results.status <= head.status;
              results.field_id <= sfr_pkg::FID_FIRST;
              acc <= head.value;
              results.sensor_warning <= 1'b0;
              results.last <= 1'b1;
              state <= S_SEND;
            end
          end
        end
        S_ADDR: begin
          state <= S_DATA;
        end
        S_DATA: begin
          acc <= (byte_idx == 2'd0) ? {24'h000000, ram_rdata} : {acc[23:0], ram_rdata};
          if ({1'b0, byte_idx} == size - 3'd1) begin
            results.status <= sfr_pkg::ST_FIELD;
            results.field_id <= fid;
            results.sensor_warning <= warn;
            results.last <= (fid == sfr_pkg::FID_LAST);
            state <= S_SEND;
          end else begin
            byte_idx <= byte_idx + 2'd1;
            state <= S_ADDR;
          end
        end
        S_SEND: begin
          if (results.ready) begin
            if (is_fields && (fid != sfr_pkg::FID_LAST)) begin
              fid <= fid + 1'b1;
              byte_idx <= 2'd0;
              state <= S_ADDR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sensor_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_receiver_unit
// Parses a sensor's framed serial byte stream and emits its measurements.
// ----------------------------------------------------------------------------
// Usage:
//   items carries one received byte (operation 0) or one millisecond tick
//   (operation 1). A frame is 0x42 0x4D, a big-endian length of 60, payload
//   and a 16-bit sum of the preceding bytes. results carries 24 field items
//   per good frame, or one status item for a bad length, a checksum mismatch
//   or a zero AQI; last marks the final item of each run. cfg writes the
//   idle timeout in ticks (reset value 500) and is always ready.
//   The parser takes one item per cycle while items.ready is high. With the
//   emitter idle, a status item is registered in the job queue and then in
//   the emitter's result registers. A field run takes the job, reads each
//   field byte through the single registered read port and presents each field.
//   A two-entry job queue sits between parser and emitter, so items keep
//   flowing while results wait. Once the next frame reaches its payload,
//   every item waits until the previous field run has been delivered, and a
//   full queue holds the input as well. A stall on results holds the current
//   item steady. Reset returns to the sync search, clears the idle timer and
//   restores the timeout; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_frame_receiver_unit (
  input  logic      clk,
  input  logic      rst,
  sfr_in_if.sink    items,
  sfr_cfg_if.sink   cfg,
  sfr_out_if.source results
);

  logic                      push;
  sfr_pkg::job_t             push_job;
  sfr_pkg::job_t             head;
  sfr_pkg::queue_stat_t      q_stat;
  logic                      pop;
  logic                      fields_done;
  logic                      ram_we;
  logic [sfr_pkg::POS_W-1:0] ram_waddr;
  logic [7:0]                ram_wdata;
  logic [sfr_pkg::POS_W-1:0] ram_raddr;
  logic [7:0]                ram_rdata;

  // Frame parser.
  sfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .cfg         (cfg),
    .q_stat      (q_stat),
    .fields_done (fields_done),
    .push        (push),
    .job         (push_job),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata)
  );

  // Frame byte store.
  sfr_ram #(
    .WIDTH (8),
    .DEPTH (sfr_pkg::FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Job queue between the two sides.
  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Result emitter.
  sfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .fields_done (fields_done),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .results     (results)
  );

  // The parser never posts a job into a full queue.
  `ASSERT_SAME(a_no_push_when_full, clk, rst, push, !q_stat.full)
  // A field run ends exactly on the error code field.
  `ASSERT_SAME(a_field_run_end, clk, rst,
    results.valid && (results.status == sfr_pkg::ST_FIELD) && results.last,
    results.field_id == sfr_pkg::FID_LAST)
  // A status item stands alone with field id zero.
  `ASSERT_SAME(a_status_alone, clk, rst,
    results.valid && (results.status != sfr_pkg::ST_FIELD),
    results.last && (results.field_id == sfr_pkg::FID_FIRST))
  // The emitter pops a job only when it has gone idle, so a pop never repeats.
  `ASSERT_NEXT(a_single_pop, clk, rst, pop, !pop)

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sensor_frame_receiver_unit with good, damaged and abandoned frames,
// noise bytes and millisecond ticks under random idling on both channels.
// A cycle-free model in this file predicts each result, and a checker
// compares the results that come out against it, field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;

  // One expected result item.
  typedef struct packed {
    sfr_pkg::status_t status;
    logic [4:0]       fid;
    logic [31:0]      value;
    logic             warn;
    logic             last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfr_in_if  items_ch ();
  sfr_cfg_if cfg_ch ();
  sfr_out_if res_ch ();

  sensor_frame_receiver_unit dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .cfg     (cfg_ch),
    .results (res_ch)
  );

  // Parser model state and the results it still owes.
  logic [15:0]               timeout_reg = sfr_pkg::TIMEOUT_RESET;
  logic [sfr_pkg::POS_W-1:0] parse_pos = sfr_pkg::POS_SYNC0;
  logic [15:0]               frame_sum = '0;
  logic [15:0]               idle_ticks = '0;
  logic [7:0]                frame_mem [sfr_pkg::FRAME_BYTES];
  result_t                   expected_q [$];

  // Frame under construction by the stimulus.
  logic [7:0] frame_buf [sfr_pkg::FRAME_BYTES];

  int results_seen = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  logic sink_stalls = 1'b1;
  bit src_gaps = 1'b1;
  result_t head;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the parser: consumes one accepted item, queues its results.
  task automatic predict_item(input logic op, input logic [7:0] b);
    logic [sfr_pkg::POS_W-1:0] p;
    logic [15:0] word;
    logic [7:0] err_code;
    logic [31:0] val;
    int ofs;
    int len;
    result_t r;
    if (op == sfr_pkg::OP_TICK) begin
      if (idle_ticks != sfr_pkg::IDLE_MAX) idle_ticks = idle_ticks + 16'd1;
      if (idle_ticks >= timeout_reg) parse_pos = sfr_pkg::POS_SYNC0;
    end else begin
      idle_ticks = '0;
      p = parse_pos;
      frame_mem[p] = b;
      r = '0;
      r.last = 1'b1;
      if (p == sfr_pkg::POS_SYNC0) begin
        frame_sum = 16'(b);
        parse_pos = (b == sfr_pkg::SYNC0) ? sfr_pkg::POS_SYNC1 : sfr_pkg::POS_SYNC0;
      end else if (p == sfr_pkg::POS_SYNC1) begin
        frame_sum = frame_sum + 16'(b);
        parse_pos = (b == sfr_pkg::SYNC1) ? sfr_pkg::POS_LEN_HI : sfr_pkg::POS_SYNC0;
      end else if (p == sfr_pkg::POS_LEN_HI) begin
        frame_sum = frame_sum + 16'(b);
        parse_pos = sfr_pkg::POS_LEN_LO;
      end else if (p == sfr_pkg::POS_LEN_LO) begin
        word = {frame_mem[sfr_pkg::POS_LEN_HI], b};
        frame_sum = frame_sum + 16'(b);
        if (word != sfr_pkg::LEN_EXPECTED) begin
          r.status = sfr_pkg::ST_BAD_LEN;
          r.value = 32'(word);
          expected_q.push_back(r);
          parse_pos = sfr_pkg::POS_SYNC0;
        end else begin
          parse_pos = sfr_pkg::POS_PAYLOAD;
        end
      end else if (p != sfr_pkg::POS_CHK_LO) begin
        // The high checksum byte is not part of the sum.
        if (p != sfr_pkg::POS_CHK_HI) frame_sum = frame_sum + 16'(b);
        parse_pos = p + 1'b1;
      end else begin
        parse_pos = sfr_pkg::POS_SYNC0;
        word = {frame_mem[sfr_pkg::POS_CHK_HI], b};
        if (word != frame_sum) begin
          r.status = sfr_pkg::ST_BAD_CHK;
          r.value = 32'(word);
          expected_q.push_back(r);
        end else if (frame_mem[sfr_pkg::POS_AQI] == 8'h00) begin
          r.status = sfr_pkg::ST_ZERO_AQI;
          expected_q.push_back(r);
        end else begin
          err_code = frame_mem[sfr_pkg::POS_ERR];
          // Fields lie in three groups, each packed back to back, then AQI and error.
          for (int k = 0; k < sfr_pkg::NUM_FIELDS; k++) begin
            if (k < 14) begin
              ofs = 4 + 2 * k;
              len = 2;
            end else if (k < 18) begin
              ofs = 8'h22 + 2 * (k - 14);
              len = 2;
            end else if (k < 22) begin
              ofs = 8'h2A + 4 * (k - 18);
              len = 4;
            end else begin
              ofs = (k == 22) ? int'(sfr_pkg::POS_AQI) : int'(sfr_pkg::POS_ERR);
              len = 1;
            end
            val = '0;
            for (int j = 0; j < len; j++) val = {val[23:0], frame_mem[ofs + j]};
            r.status = sfr_pkg::ST_FIELD;
            r.fid = 5'(k);
            r.value = val;
            r.warn = (err_code != 8'h00);
            r.last = (k == sfr_pkg::NUM_FIELDS - 1);
            expected_q.push_back(r);
          end
        end
      end
    end
  endtask

  // Offers one item, with an occasional random gap first, and waits for it.
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    if (src_gaps && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.operation <= op;
    items_ch.rx_byte <= b;
    do @(posedge clk); while (!items_ch.ready);
    predict_item(op, b);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(sfr_pkg::OP_TICK, 8'($urandom));
  endtask

  // Sends part of the frame buffer, sometimes with a tick or two between bytes.
  task automatic send_bytes(input int first, input int count, input int tick_odds);
    for (int i = first; i < first + count; i++) begin
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1)
        send_ticks($urandom_range(1, 2));
      send_item(sfr_pkg::OP_BYTE, frame_buf[i]);
    end
  endtask

  // Builds a well-formed frame; a negative fill means random payload bytes.
  task automatic build_frame(input int fill, input logic [7:0] aqi, input logic [7:0] err);
    logic [15:0] sum;
    frame_buf[sfr_pkg::POS_SYNC0] = sfr_pkg::SYNC0;
    frame_buf[sfr_pkg::POS_SYNC1] = sfr_pkg::SYNC1;
    frame_buf[sfr_pkg::POS_LEN_HI] = sfr_pkg::LEN_EXPECTED[15:8];
    frame_buf[sfr_pkg::POS_LEN_LO] = sfr_pkg::LEN_EXPECTED[7:0];
    for (int i = int'(sfr_pkg::POS_PAYLOAD); i < sfr_pkg::FRAME_BYTES - 2; i++)
      frame_buf[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    frame_buf[sfr_pkg::POS_AQI] = aqi;
    frame_buf[sfr_pkg::POS_ERR] = err;
    sum = '0;
    for (int i = 0; i < sfr_pkg::FRAME_BYTES - 2; i++) sum = sum + 16'(frame_buf[i]);
    frame_buf[sfr_pkg::POS_CHK_HI] = sum[15:8];
    frame_buf[sfr_pkg::POS_CHK_LO] = sum[7:0];
  endtask

  // Drops the input valid and waits until every owed result has come out.
  task automatic wait_drained();
    items_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.timeout_ticks <= ticks;
    do @(posedge clk); while (!cfg_ch.ready);
    timeout_reg = ticks;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
  endtask

  // Wrong sync bytes are dropped without a second look.
  task automatic check_sync_search();
    send_item(sfr_pkg::OP_BYTE, 8'h00);
    send_item(sfr_pkg::OP_BYTE, sfr_pkg::SYNC1);
    send_item(sfr_pkg::OP_BYTE, sfr_pkg::SYNC0);
    send_item(sfr_pkg::OP_BYTE, sfr_pkg::SYNC0);
    send_item(sfr_pkg::OP_BYTE, sfr_pkg::SYNC1);
  endtask

  // Bad lengths pile up while the result side holds off, so the input stalls.
  task automatic check_backpressure();
    logic [15:0] bad_lens [3] = '{16'h0000, 16'hFFFF, 16'h003D};
    src_gaps = 1'b0;
    hold_req <= ~hold_req;
    foreach (bad_lens[i]) begin
      build_frame(-1, 8'h10, 8'h00);
      {frame_buf[sfr_pkg::POS_LEN_HI], frame_buf[sfr_pkg::POS_LEN_LO]} = bad_lens[i];
      send_bytes(0, 4, 0);
    end
    // The queue is full by now, so this byte waits for the hold-off to end.
    send_item(sfr_pkg::OP_BYTE, 8'h00);
    wait_drained();
    src_gaps = 1'b1;
  endtask

  // A good frame with random content and a sensor warning.
  task automatic check_good_frame();
    build_frame(-1, 8'h80, 8'h01);
    send_bytes(0, sfr_pkg::FRAME_BYTES, 0);
  endtask

  // Follows the good frame directly, so its payload waits for the field run.
  task automatic check_bad_checksum();
    build_frame(-1, 8'h33, 8'h00);
    frame_buf[sfr_pkg::POS_CHK_LO] ^= 8'h01;
    send_bytes(0, sfr_pkg::FRAME_BYTES, 0);
  endtask

  // Idle ticks below the timeout, at the timeout, and with a zero timeout.
  task automatic check_idle_timeout();
    write_timeout(16'd2);
    build_frame(-1, 8'h21, 8'h00);
    send_bytes(0, 2, 0);
    send_ticks(1);
    send_bytes(2, 1, 0);
    send_ticks(2);
    send_bytes(3, 1, 0);

    // With a zero timeout every tick restarts the search.
    write_timeout(16'd0);
    send_bytes(0, 1, 0);
    send_ticks(1);
    send_item(sfr_pkg::OP_BYTE, sfr_pkg::SYNC1);
  endtask

  // A zero AQI frame with a few ticks that stay under the timeout.
  task automatic check_zero_aqi();
    write_timeout(16'd3);
    build_frame(-1, 8'h00, 8'hFF);
    send_bytes(0, sfr_pkg::FRAME_BYTES, 30);
  endtask

  // Result side: random stall bursts, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Counts out the long hold-off after each request.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item, value", res_ch.field_value, '0);
      end else begin
        head = expected_q.pop_front();
        if (res_ch.status !== head.status)
          report_mismatch("status", 32'(res_ch.status), 32'(head.status));
        if (res_ch.field_id !== head.fid)
          report_mismatch("field_id", 32'(res_ch.field_id), 32'(head.fid));
        if (res_ch.field_value !== head.value)
          report_mismatch("field_value", res_ch.field_value, head.value);
        if (res_ch.sensor_warning !== head.warn)
          report_mismatch("sensor_warning", 32'(res_ch.sensor_warning), 32'(head.warn));
        if (res_ch.last !== head.last)
          report_mismatch("last", 32'(res_ch.last), 32'(head.last));
      end
    end
  end

  // Ends a run that has stopped moving.
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** sensor_frame_receiver_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    items_ch.valid = 1'b0;
    items_ch.operation = sfr_pkg::OP_BYTE;
    items_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.timeout_ticks = sfr_pkg::TIMEOUT_RESET;
    res_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_sync_search();
    check_backpressure();
    check_good_frame();
    check_bad_checksum();
    check_idle_timeout();

    // Closing stretch at full rate on both sides.
    wait_drained();
    src_gaps = 1'b0;
    sink_stalls <= 1'b0;
    check_zero_aqi();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("** sensor_frame_receiver_unit: PASSED **");
    end else begin
      $display("** sensor_frame_receiver_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_in_if.sv
rtl/sfr_out_if.sv
rtl/sfr_cfg_if.sv
rtl/sfr_ram.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/sensor_frame_receiver_unit.sv
test/testbench.sv
